>>> sv/pgac_pkg.sv
// ---------------------------------------------------------------------------
// pgac_pkg
// Shared types, constants and direction/trig tables for the particle-gamma
// angle cosine pipeline.
// ---------------------------------------------------------------------------
package pgac_pkg;

    localparam int GE_MODULES  = 5;
    localparam int GE_CHANNELS = 16;

    localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

    localparam logic [2:0] ADDR_BEAM_X   = 3'd0;
    localparam logic [2:0] ADDR_BEAM_Y   = 3'd1;
    localparam logic [2:0] ADDR_BEAM_Z   = 3'd2;
    localparam logic [2:0] ADDR_TARGET   = 3'd3;
    localparam logic [2:0] ADDR_INNER_R  = 3'd4;

    localparam int SQRT_STEPS = 25;
    localparam int DIV_STEPS  = 17;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } gvec_t;

    function automatic gvec_t mk(input int x, input int y, input int z);
        gvec_t v;
        v.x = 16'(x);
        v.y = 16'(y);
        v.z = 16'(z);
        return v;
    endfunction

    function automatic logic signed [15:0] sin_oct(input logic [3:0] k);
        logic signed [15:0] v;
        case (k)
            4'd0:    v = 16'sd0;
            4'd1:    v = 16'sd3196;
            4'd2:    v = 16'sd6270;
            4'd3:    v = 16'sd9102;
            4'd4:    v = 16'sd11585;
            4'd5:    v = 16'sd13623;
            4'd6:    v = 16'sd15137;
            4'd7:    v = 16'sd16069;
            4'd8:    v = 16'sd16384;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // sin(k * 11.25 deg), Q1.14, one full turn over 32 steps
    function automatic logic signed [15:0] sin_step(input logic [4:0] k);
        logic signed [15:0] v;
        v = k[3] ? sin_oct(4'd8 - {1'b0, k[2:0]}) : sin_oct({1'b0, k[2:0]});
        return k[4] ? -v : v;
    endfunction

    function automatic gvec_t gamma_dir(input logic [2:0] m, input logic [3:0] ch);
        gvec_t v;
        v = mk(0, 0, 16384);
        case (m)
            3'd0: begin
                case (ch)
                    4'd0:    v = mk(2763, 6671, -14707);
                    4'd1:    v = mk(-6671, 2763, -14707);
                    4'd2:    v = mk(-2763, -6671, -14707);
                    4'd3:    v = mk(6671, -2763, -14707);
                    4'd4:    v = mk(11879, 4920, -10154);
                    4'd5:    v = mk(-4920, 11879, -10154);
                    4'd6:    v = mk(-11879, -4920, -10154);
                    4'd7:    v = mk(4920, -11879, -10154);
                    default: v = mk(0, 0, 16384);
                endcase
            end
            3'd1: begin
                case (ch)
                    4'd0:    v = mk(4920, 11879, 10154);
                    4'd1:    v = mk(-11879, 4920, 10154);
                    4'd2:    v = mk(-4920, -11879, 10154);
                    4'd3:    v = mk(11879, -4920, 10154);
                    4'd4:    v = mk(6671, 2763, 14707);
                    4'd5:    v = mk(-2763, 6671, 14707);
                    4'd6:    v = mk(-6671, -2763, 14707);
                    4'd7:    v = mk(2763, -6671, 14707);
                    default: v = mk(0, 0, 16384);
                endcase
            end
            3'd2: begin
                case (ch[3:2])
                    2'd0:    v = mk(15137, 6270, 0);
                    2'd1:    v = mk(6270, 15137, 0);
                    2'd2:    v = mk(-6270, 15137, 0);
                    default: v = mk(0, 0, 16384);
                endcase
            end
            3'd3: begin
                case (ch[3:2])
                    2'd0:    v = mk(-15137, -6270, 0);
                    2'd2:    v = mk(-6270, -15137, 0);
                    default: v = mk(0, 0, 16384);
                endcase
            end
            3'd4: begin
                case (ch[3:2])
                    2'd0:    v = mk(6270, -15137, 0);
                    2'd1:    v = mk(16384, 0, 0);
                    2'd2:    v = mk(15137, -6270, 0);
                    default: v = mk(0, 0, 16384);
                endcase
            end
            default: v = mk(0, 0, 16384);
        endcase
        return v;
    endfunction

endpackage

>>> sv/particle_gamma_angle_cosine.sv
// ---------------------------------------------------------------------------
// particle_gamma_angle_cosine
// Cosine of the angle between a gamma detector direction and the vector from
// the beam spot to a silicon pixel, Q1.14, fully pipelined.
// ---------------------------------------------------------------------------
//  channel   | dir | ports               | payload
//  s_axis    | in  | tvalid/tready/tdata | module, channel, ring, sector
//  m_axis    | out | tvalid/tready/tdata | cos_angle (tdata), valid_res (tuser)
//  apb       | in  | psel/penable/...    | beam_x/y/z, target_distance, inner_radius
//
//  One request per cycle while the output is not stalled: 25 square-root
//  stages and 17 divider stages, one result bit per stage, set the depth.
//  aresetn is synchronous; it empties the pipeline and restores registers.
//  Each stage holds while the one after it is full and stalled; empty
//  stages fill in, so a request is taken while a result waits.
// ---------------------------------------------------------------------------
module particle_gamma_angle_cosine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] ge_module, [6:3] ge_channel, [11:7] si_ring, [16:12] si_sector
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] cos_angle
    output logic [15:0] m_axis_tdata,
    // [0] valid_res
    output logic        m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SQ0 = 5;
    localparam int DV_SETUP = SQ0 + pgac_pkg::SQRT_STEPS;
    localparam int DV0 = DV_SETUP + 1;
    localparam int OUTS = DV0 + pgac_pkg::DIV_STEPS;
    localparam int NST = OUTS + 1;

    // configuration
    logic signed [15:0] beam_x_reg, beam_y_reg, beam_z_reg;
    logic [14:0]        target_reg, inner_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beam_x_reg <= '0;
            beam_y_reg <= '0;
            beam_z_reg <= '0;
            target_reg <= 15'd2560;
            inner_reg  <= 15'd2944;
        end else if (wr_en) begin
            case (paddr[4:2])
                pgac_pkg::ADDR_BEAM_X:  beam_x_reg <= pwdata[15:0];
                pgac_pkg::ADDR_BEAM_Y:  beam_y_reg <= pwdata[15:0];
                pgac_pkg::ADDR_BEAM_Z:  beam_z_reg <= pwdata[15:0];
                pgac_pkg::ADDR_TARGET:  target_reg <= pwdata[14:0];
                pgac_pkg::ADDR_INNER_R: inner_reg  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            pgac_pkg::ADDR_BEAM_X:  prdata = {{16{beam_x_reg[15]}}, beam_x_reg};
            pgac_pkg::ADDR_BEAM_Y:  prdata = {{16{beam_y_reg[15]}}, beam_y_reg};
            pgac_pkg::ADDR_BEAM_Z:  prdata = {{16{beam_z_reg[15]}}, beam_z_reg};
            pgac_pkg::ADDR_TARGET:  prdata = {17'd0, target_reg};
            pgac_pkg::ADDR_INNER_R: prdata = {17'd0, inner_reg};
            default:                prdata = '0;
        endcase
    end

    // stage flow control
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] en;

    always_comb begin
        en[NST-1] = !vld_reg[NST-1] || m_axis_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NST; i++) begin
                if (en[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign s_axis_tready = en[0];

    // stage 0: table lookup, radius
    logic [2:0] in_mod;
    logic [3:0] in_ch;
    logic [4:0] in_ring, in_sec;
    assign in_mod  = s_axis_tdata[2:0];
    assign in_ch   = s_axis_tdata[6:3];
    assign in_ring = s_axis_tdata[11:7];
    assign in_sec  = s_axis_tdata[16:12];

    pgac_pkg::gvec_t    g0_reg;
    logic signed [15:0] ctrig0_reg, strig0_reg;
    logic [15:0]        r0_reg;
    logic               ok0_reg;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            g0_reg     <= pgac_pkg::gamma_dir(in_mod, in_ch);
            ctrig0_reg <= -pgac_pkg::sin_step(in_sec);
            strig0_reg <= pgac_pkg::sin_step(in_sec + 5'd8);
            r0_reg     <= {1'b0, inner_reg} + {3'd0, in_ring, 8'd0};
            ok0_reg    <= (32'(in_mod) < pgac_pkg::GE_MODULES)
                       && (32'(in_ch) < pgac_pkg::GE_CHANNELS);
        end
    end

    // stage 1: pixel position products
    pgac_pkg::gvec_t    g1_reg;
    logic signed [32:0] pxp1_reg, pyp1_reg;
    logic               ok1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            g1_reg   <= g0_reg;
            pxp1_reg <= $signed({1'b0, r0_reg}) * ctrig0_reg;
            pyp1_reg <= $signed({1'b0, r0_reg}) * strig0_reg;
            ok1_reg  <= ok0_reg;
        end
    end

    // stage 2: round, offset from beam spot
    logic signed [33:0] pxr, pyr;
    assign pxr = ($signed({pxp1_reg[32], pxp1_reg}) + 34'sd8192) >>> 14;
    assign pyr = ($signed({pyp1_reg[32], pyp1_reg}) + 34'sd8192) >>> 14;

    pgac_pkg::gvec_t    g2_reg;
    logic signed [17:0] dx2_reg, dy2_reg, dz2_reg;
    logic               ok2_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            g2_reg  <= g1_reg;
            dx2_reg <= 18'(pxr) - 18'(beam_x_reg);
            dy2_reg <= 18'(pyr) - 18'(beam_y_reg);
            dz2_reg <= $signed({3'd0, target_reg}) - 18'(beam_z_reg);
            ok2_reg <= ok1_reg;
        end
    end

    // stage 3: squares and projections
    logic [35:0]        sxx3_reg, syy3_reg, szz3_reg;
    logic signed [33:0] px3_reg, py3_reg, pz3_reg;
    logic               ok3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            sxx3_reg <= 36'(dx2_reg * dx2_reg);
            syy3_reg <= 36'(dy2_reg * dy2_reg);
            szz3_reg <= 36'(dz2_reg * dz2_reg);
            px3_reg  <= dx2_reg * g2_reg.x;
            py3_reg  <= dy2_reg * g2_reg.y;
            pz3_reg  <= dz2_reg * g2_reg.z;
            ok3_reg  <= ok2_reg;
        end
    end

    // stage 4: sums
    logic [35:0]        len2_sum;
    logic [33:0]        len2_4_reg;
    logic signed [35:0] dot4_reg;
    logic               ok4_reg;
    assign len2_sum = sxx3_reg + syy3_reg + szz3_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            len2_4_reg <= len2_sum[33:0];
            dot4_reg   <= 36'(px3_reg) + 36'(py3_reg) + 36'(pz3_reg);
            ok4_reg    <= ok3_reg && (len2_sum != '0);
        end
    end

    // square root, one result bit per stage
    logic [49:0]        sq_x_reg    [pgac_pkg::SQRT_STEPS];
    logic [26:0]        sq_rem_reg  [pgac_pkg::SQRT_STEPS];
    logic [24:0]        sq_root_reg [pgac_pkg::SQRT_STEPS];
    logic signed [35:0] sq_dot_reg  [pgac_pkg::SQRT_STEPS];
    logic               sq_ok_reg   [pgac_pkg::SQRT_STEPS];

    for (genvar j = 0; j < pgac_pkg::SQRT_STEPS; j++) begin : g_sqrt
        logic [49:0]        x_in;
        logic [26:0]        rem_in;
        logic [24:0]        root_in;
        logic signed [35:0] dot_in;
        logic               ok_in;
        logic [27:0]        remsh, trial;

        if (j == 0) begin : g_first
            assign x_in    = {len2_4_reg, 16'd0};
            assign rem_in  = '0;
            assign root_in = '0;
            assign dot_in  = dot4_reg;
            assign ok_in   = ok4_reg;
        end else begin : g_next
            assign x_in    = sq_x_reg[j-1];
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
            assign dot_in  = sq_dot_reg[j-1];
            assign ok_in   = sq_ok_reg[j-1];
        end

        assign remsh = {rem_in[25:0], x_in[49:48]};
        assign trial = {1'b0, root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (en[SQ0+j]) begin
                sq_x_reg[j]   <= {x_in[47:0], 2'b00};
                if (remsh >= trial) begin
                    sq_rem_reg[j]  <= 27'(remsh - trial);
                    sq_root_reg[j] <= {root_in[23:0], 1'b1};
                end else begin
                    sq_rem_reg[j]  <= remsh[26:0];
                    sq_root_reg[j] <= {root_in[23:0], 1'b0};
                end
                sq_dot_reg[j] <= dot_in;
                sq_ok_reg[j]  <= ok_in;
            end
        end
    end

    // divider setup: magnitude, rounding term
    logic [24:0] len_s;
    logic [35:0] mag_s;
    logic [45:0] num_s;
    assign len_s = sq_root_reg[pgac_pkg::SQRT_STEPS-1];
    assign mag_s = sq_dot_reg[pgac_pkg::SQRT_STEPS-1][35]
                 ? 36'(-sq_dot_reg[pgac_pkg::SQRT_STEPS-1])
                 : 36'(sq_dot_reg[pgac_pkg::SQRT_STEPS-1]);
    assign num_s = {2'b00, mag_s[35:0], 8'd0} + {22'd0, len_s[24:1]};

    logic [24:0] ds_rem_reg, ds_len_reg;
    logic [16:0] ds_num_reg;
    logic        ds_neg_reg, ds_ok_reg;

    always_ff @(posedge aclk) begin
        if (en[DV_SETUP]) begin
            ds_rem_reg <= num_s[41:17];
            ds_num_reg <= num_s[16:0];
            ds_len_reg <= len_s;
            ds_neg_reg <= sq_dot_reg[pgac_pkg::SQRT_STEPS-1][35];
            ds_ok_reg  <= sq_ok_reg[pgac_pkg::SQRT_STEPS-1];
        end
    end

    // restoring divider, one quotient bit per stage
    logic [24:0] dv_rem_reg [pgac_pkg::DIV_STEPS];
    logic [24:0] dv_len_reg [pgac_pkg::DIV_STEPS];
    logic [16:0] dv_num_reg [pgac_pkg::DIV_STEPS];
    logic [16:0] dv_q_reg   [pgac_pkg::DIV_STEPS];
    logic        dv_neg_reg [pgac_pkg::DIV_STEPS];
    logic        dv_ok_reg  [pgac_pkg::DIV_STEPS];

    for (genvar j = 0; j < pgac_pkg::DIV_STEPS; j++) begin : g_div
        logic [24:0] rem_in, len_in;
        logic [16:0] num_in, q_in;
        logic        neg_in, ok_in;
        logic [25:0] remsh;

        if (j == 0) begin : g_first
            assign rem_in = ds_rem_reg;
            assign len_in = ds_len_reg;
            assign num_in = ds_num_reg;
            assign q_in   = '0;
            assign neg_in = ds_neg_reg;
            assign ok_in  = ds_ok_reg;
        end else begin : g_next
            assign rem_in = dv_rem_reg[j-1];
            assign len_in = dv_len_reg[j-1];
            assign num_in = dv_num_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            assign neg_in = dv_neg_reg[j-1];
            assign ok_in  = dv_ok_reg[j-1];
        end

        assign remsh = {rem_in, num_in[16]};

        always_ff @(posedge aclk) begin
            if (en[DV0+j]) begin
                if (remsh >= {1'b0, len_in}) begin
                    dv_rem_reg[j] <= 25'(remsh - {1'b0, len_in});
                    dv_q_reg[j]   <= {q_in[15:0], 1'b1};
                end else begin
                    dv_rem_reg[j] <= remsh[24:0];
                    dv_q_reg[j]   <= {q_in[15:0], 1'b0};
                end
                dv_len_reg[j] <= len_in;
                dv_num_reg[j] <= {num_in[15:0], 1'b0};
                dv_neg_reg[j] <= neg_in;
                dv_ok_reg[j]  <= ok_in;
            end
        end
    end

    // output: saturate, restore sign
    logic [16:0]        q_f;
    logic signed [15:0] mag_f;
    assign q_f   = dv_q_reg[pgac_pkg::DIV_STEPS-1];
    assign mag_f = (q_f > 17'(pgac_pkg::ONE_Q14)) ? pgac_pkg::ONE_Q14 : q_f[15:0];

    logic [15:0] cos_reg;
    logic        vres_reg;

    always_ff @(posedge aclk) begin
        if (en[OUTS]) begin
            if (dv_ok_reg[pgac_pkg::DIV_STEPS-1]) begin
                cos_reg <= dv_neg_reg[pgac_pkg::DIV_STEPS-1] ? -mag_f : mag_f;
            end else begin
                cos_reg <= '0;
            end
            vres_reg <= dv_ok_reg[pgac_pkg::DIV_STEPS-1];
        end
    end

    assign m_axis_tvalid = vld_reg[NST-1];
    assign m_axis_tdata  = cos_reg;
    assign m_axis_tuser  = vres_reg;

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid result carries nonzero cosine");

    a_saturated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= pgac_pkg::ONE_Q14
                        && $signed(m_axis_tdata) >= -pgac_pkg::ONE_Q14))
        else $error("cosine outside unit range");

    a_ready_when_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !vld_reg[NST-1] |-> s_axis_tready)
        else $error("input stalled with empty output stage");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NST-2] && !en[NST-1]) |=> vld_reg[NST-2])
        else $error("request lost in stalled pipeline");

endmodule
